// File: design/csd_pkg.sv
`default_nettype none

package csd_pkg;

    localparam int CARD_W         = 4;
    localparam int FIELD_W        = 9;
    localparam int MODE_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int CFG_W          = 4;
    localparam int CARDS_PER_DECK = 52;
    localparam int RANKS          = 13;
    localparam int ACE_VALUE      = 11;
    localparam int FACE_VALUE     = 10;

    localparam logic [CARD_W-1:0] RANK_ACE  = CARD_W'(1);
    localparam logic [CARD_W-1:0] RANK_TEN  = CARD_W'(10);
    localparam logic [CARD_W-1:0] RANK_KING = CARD_W'(RANKS);

    typedef enum logic [MODE_W-1:0] {
        MODE_BUILD   = 2'd0,
        MODE_SHUFFLE = 2'd1,
        MODE_DEAL    = 2'd2,
        MODE_IGNORE  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_SW_RD_POS,
        S_SW_RD_IDX,
        S_SW_WR_POS,
        S_SW_WR_IDX,
        S_DEAL_RD,
        S_DEAL_CAP,
        S_RESULT
    } t_state;

    typedef enum logic [2:0] {
        RAM_IDLE,
        RAM_RD_POS,
        RAM_RD_IDX,
        RAM_RD_PTR,
        RAM_WR_FILL,
        RAM_WR_POS,
        RAM_WR_IDX
    } t_ram_op;

    typedef struct packed {
        logic    latch_item;
        logic    decode;
        logic    fill_start;
        t_ram_op ram_op;
        logic    hold_card;
        logic    pos_dec;
        logic    deal_take;
        logic    load_result;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  pos_zero;
        logic  idx_over;
        logic  shoe_empty;
        logic  fill_last;
        logic  out_free;
    } t_dp_status;

    function automatic logic [CARD_W-1:0] card_value(input logic [CARD_W-1:0] rank);
        logic [CARD_W-1:0] v;
        if (rank == RANK_ACE) begin
            v = CARD_W'(ACE_VALUE);
        end else if (rank >= RANK_TEN) begin
            v = CARD_W'(FACE_VALUE);
        end else begin
            v = rank;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: design/csd_in_if.sv
`default_nettype none

interface csd_in_if;
    import csd_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [FIELD_W-1:0]  swap_index;

    modport source (output valid, output mode, output swap_index, input ready);
    modport sink   (input valid, input mode, input swap_index, output ready);
endinterface

`default_nettype wire

// File: design/csd_out_if.sv
`default_nettype none

interface csd_out_if;
    import csd_pkg::*;

    logic                valid;
    logic                ready;
    logic [CARD_W-1:0]   card_rank;
    logic [CARD_W-1:0]   card_value;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  cards_left;
    logic                shuffle_done;

    modport source (output valid, output card_rank, output card_value, output status,
                    output cards_left, output shuffle_done, input ready);
    modport sink   (input valid, input card_rank, input card_value, input status,
                    input cards_left, input shuffle_done, output ready);
endinterface

`default_nettype wire

// File: design/csd_ram.sv
`default_nettype none

module csd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 416
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/csd_ctrl.sv
`default_nettype none

module csd_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire csd_pkg::t_dp_status i_status,
    output csd_pkg::t_dp_cmd         o_cmd
);
    import csd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.ram_op = RAM_IDLE;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_item = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                case (i_status.mode)
                    MODE_BUILD: begin
                        o_cmd.fill_start = 1'b1;
                        n_state = S_FILL;
                    end
                    MODE_SHUFFLE: begin
                        if (i_status.pos_zero || i_status.idx_over) begin
                            n_state = S_RESULT;
                        end else begin
                            n_state = S_SW_RD_POS;
                        end
                    end
                    MODE_DEAL: begin
                        if (i_status.shoe_empty) begin
                            n_state = S_RESULT;
                        end else begin
                            n_state = S_DEAL_RD;
                        end
                    end
                    default: begin
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_FILL: begin
                o_cmd.ram_op = RAM_WR_FILL;
                if (i_status.fill_last) begin
                    n_state = S_RESULT;
                end
            end
            S_SW_RD_POS: begin
                o_cmd.ram_op = RAM_RD_POS;
                n_state = S_SW_RD_IDX;
            end
            S_SW_RD_IDX: begin
                // card at the position arrives now; park it while idx is read
                o_cmd.ram_op    = RAM_RD_IDX;
                o_cmd.hold_card = 1'b1;
                n_state = S_SW_WR_POS;
            end
            S_SW_WR_POS: begin
                o_cmd.ram_op = RAM_WR_POS;
                n_state = S_SW_WR_IDX;
            end
            S_SW_WR_IDX: begin
                o_cmd.ram_op  = RAM_WR_IDX;
                o_cmd.pos_dec = 1'b1;
                n_state = S_RESULT;
            end
            S_DEAL_RD: begin
                o_cmd.ram_op = RAM_RD_PTR;
                n_state = S_DEAL_CAP;
            end
            S_DEAL_CAP: begin
                o_cmd.deal_take = 1'b1;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/csd_dp.sv
`default_nettype none

module csd_dp #(
    parameter int MAX_DECKS = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [csd_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  wire logic [csd_pkg::MODE_W-1:0] i_mode,
    input  wire logic [csd_pkg::FIELD_W-1:0] i_swap_index,
    input  wire csd_pkg::t_dp_cmd           i_cmd,
    output csd_pkg::t_dp_status             o_status,
    csd_out_if.source                       o_out
);
    import csd_pkg::*;

    localparam int DEPTH = MAX_DECKS * CARDS_PER_DECK;
    localparam int RW    = $clog2(DEPTH);
    localparam int AW    = $clog2(DEPTH + 1);
    localparam int CW    = (AW > FIELD_W) ? AW : FIELD_W;
    localparam int DW    = $clog2(MAX_DECKS + 1);
    localparam int DCW   = (DW > CFG_W) ? DW : CFG_W;

    logic [CFG_W-1:0]   r_deck_count;
    t_mode              r_mode;
    logic [FIELD_W-1:0] r_swap_index;
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      r_ptr;
    logic [AW-1:0]      r_remaining;
    logic [AW-1:0]      r_size;
    logic [AW-1:0]      r_fill_addr;
    logic [CARD_W-1:0]  r_fill_rank;
    logic [CARD_W-1:0]  r_card;
    t_status            r_status;
    logic [CARD_W-1:0]  r_rank;
    logic               r_out_valid;
    logic [CARD_W-1:0]  r_out_rank;
    logic [CARD_W-1:0]  r_out_value;
    t_status            r_out_status;
    logic [FIELD_W-1:0] r_out_left;
    logic               r_out_done;

    logic [DCW-1:0]     deck_ext;
    logic [DCW-1:0]     decks_eff;
    logic [AW-1:0]      new_size;
    logic [CW-1:0]      idx_ext;
    logic [CW-1:0]      rem_ext;
    logic               idx_over;
    logic               ram_we;
    logic [RW-1:0]      ram_addr;
    logic [CARD_W-1:0]  ram_wdata;
    logic [CARD_W-1:0]  ram_rdata;

    // deck count 0 means one deck, large counts clip to the store size
    always_comb begin
        deck_ext = DCW'(r_deck_count);
        if (deck_ext == '0) begin
            decks_eff = DCW'(1);
        end else if (deck_ext > DCW'(MAX_DECKS)) begin
            decks_eff = DCW'(MAX_DECKS);
        end else begin
            decks_eff = deck_ext;
        end
        new_size = AW'(decks_eff) * AW'(CARDS_PER_DECK);
    end

    assign idx_ext  = CW'(r_swap_index);
    assign rem_ext  = CW'(r_remaining);
    assign idx_over = idx_ext > CW'(r_pos);

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = '0;
        ram_wdata = r_fill_rank;
        case (i_cmd.ram_op)
            RAM_RD_POS: begin
                ram_addr = r_pos[RW-1:0];
            end
            RAM_RD_IDX: begin
                ram_addr = idx_ext[RW-1:0];
            end
            RAM_RD_PTR: begin
                ram_addr = r_ptr[RW-1:0];
            end
            RAM_WR_FILL: begin
                ram_we   = 1'b1;
                ram_addr = r_fill_addr[RW-1:0];
            end
            RAM_WR_POS: begin
                ram_we    = 1'b1;
                ram_addr  = r_pos[RW-1:0];
                ram_wdata = ram_rdata;
            end
            RAM_WR_IDX: begin
                ram_we    = 1'b1;
                ram_addr  = idx_ext[RW-1:0];
                ram_wdata = r_card;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    csd_ram #(
        .WIDTH (CARD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deck_count <= CFG_W'(1);
            r_pos        <= '0;
            r_ptr        <= '0;
            r_remaining  <= '0;
            r_size       <= '0;
            r_fill_addr  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_deck_count <= i_cfg_wdata;
            end
            if (i_cmd.fill_start) begin
                r_size      <= new_size;
                r_remaining <= new_size;
                r_pos       <= new_size - AW'(1);
                r_ptr       <= '0;
                r_fill_addr <= '0;
            end
            if (i_cmd.ram_op == RAM_WR_FILL) begin
                r_fill_addr <= r_fill_addr + AW'(1);
            end
            if (i_cmd.pos_dec) begin
                r_pos <= r_pos - AW'(1);
            end
            if (i_cmd.deal_take) begin
                r_ptr       <= r_ptr + AW'(1);
                r_remaining <= r_remaining - AW'(1);
            end
            if (i_cmd.load_result) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_item) begin
            r_mode       <= t_mode'(i_mode);
            r_swap_index <= i_swap_index;
        end
        if (i_cmd.fill_start) begin
            r_fill_rank <= RANK_ACE;
        end else if (i_cmd.ram_op == RAM_WR_FILL) begin
            r_fill_rank <= (r_fill_rank == RANK_KING) ? RANK_ACE : r_fill_rank + CARD_W'(1);
        end
        if (i_cmd.hold_card) begin
            r_card <= ram_rdata;
        end
        if (i_cmd.decode) begin
            r_rank <= '0;
            if (r_mode == MODE_SHUFFLE && r_pos != '0 && idx_over) begin
                r_status <= STAT_RANGE;
            end else if (r_mode == MODE_DEAL && r_remaining == '0) begin
                r_status <= STAT_EMPTY;
            end else begin
                r_status <= STAT_OK;
            end
        end
        if (i_cmd.deal_take) begin
            r_rank <= ram_rdata;
        end
        if (i_cmd.load_result) begin
            r_out_rank   <= r_rank;
            r_out_value  <= card_value(r_rank);
            r_out_status <= r_status;
            r_out_left   <= rem_ext[FIELD_W-1:0];
            r_out_done   <= (r_pos == '0);
        end
    end

    always_comb begin
        o_status.mode       = r_mode;
        o_status.pos_zero   = (r_pos == '0);
        o_status.idx_over   = idx_over;
        o_status.shoe_empty = (r_remaining == '0);
        o_status.fill_last  = (r_fill_addr == r_size - AW'(1));
        o_status.out_free   = !r_out_valid || o_out.ready;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.card_rank    = r_out_rank;
    assign o_out.card_value   = r_out_value;
    assign o_out.status       = r_out_status;
    assign o_out.cards_left   = r_out_left;
    assign o_out.shuffle_done = r_out_done;

endmodule

`default_nettype wire

// File: design/card_shoe_shuffle_deal.sv
// channel | dir | handshake    | word
// i_in    | in  | valid/ready  | mode, swap_index
// o_out   | out | valid/ready  | card_rank, card_value, status, cards_left, shuffle_done
// i_cfg   | in  | write enable | deck_count (4 bits)
//
// A build writes 52 cards per deck used (one store write a cycle); a swapping shuffle step
// makes two reads and two writes through the single-port card store; a dealt card takes one
// registered store read; empty deals, rejected or idle shuffle steps and mode 3 touch no
// store and go straight to the result.
// The result register lets the next word in while a result waits; a stalled
// output holds the block in its result state until the slot frees.
// Reset is synchronous; the card store is not cleared and is only read after a build.
`default_nettype none

module card_shoe_shuffle_deal #(
    parameter int MAX_DECKS = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [csd_pkg::CFG_W-1:0]  i_cfg_wdata,
    csd_in_if.sink                          i_in,
    csd_out_if.source                       o_out
);
    import csd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status dp_status;
    logic       in_ready;

    csd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    csd_dp #(
        .MAX_DECKS (MAX_DECKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_mode       (i_in.mode),
        .i_swap_index (i_in.swap_index),
        .i_cmd        (cmd),
        .o_status     (dp_status),
        .o_out        (o_out)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire

// File: design/csd_checker.sv
`default_nettype none

module csd_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [csd_pkg::CARD_W-1:0]   i_card_rank,
    input wire logic [csd_pkg::CARD_W-1:0]   i_card_value,
    input wire logic [csd_pkg::STATUS_W-1:0] i_status,
    input wire logic [csd_pkg::FIELD_W-1:0]  i_cards_left,
    input wire logic                         i_shuffle_done
);
    import csd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_card_rank)
            && $stable(i_status) && $stable(i_cards_left) && $stable(i_shuffle_done))
        else $error("result word changed while stalled");

    // a dealt card carries a consistent value, a missing card carries none
    a_rank_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_card_rank == '0) == (i_card_value == '0)
            && ((i_card_rank == RANK_ACE) == (i_card_value == CARD_W'(ACE_VALUE))))
        else $error("card value does not match rank");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == STAT_EMPTY |-> i_card_rank == '0 && i_cards_left == '0)
        else $error("empty shoe reported with cards");

    // a rejected swap only happens with shuffle work left
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == STAT_RANGE |-> !i_shuffle_done && i_card_rank == '0)
        else $error("range error with finished shuffle");

endmodule

bind card_shoe_shuffle_deal csd_checker u_csd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_card_rank    (o_out.card_rank),
    .i_card_value   (o_out.card_value),
    .i_status       (o_out.status),
    .i_cards_left   (o_out.cards_left),
    .i_shuffle_done (o_out.shuffle_done)
);

`default_nettype wire
